// ----- sv/epcal_pkg.sv -----
// ----------------------------------------------------------------------------
// epcal_pkg: shared types and constants for the epoch seconds to calendar core
// Item and result records, register codes, reciprocal multipliers for the
// constant divisions and the month-start table.
// ----------------------------------------------------------------------------
package epcal_pkg;

	// configuration register codes
	typedef enum logic [1:0] {
		REG_EPOCH_BASE_DAYS     = 2'd0,
		REG_ZONE_OFFSET_SECONDS = 2'd1
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [15:0] BASE_DAYS_RESET = 16'd25567;
	localparam logic [31:0] HALF_DAY_SECS   = 32'd43200;
	// one day of bias keeps the adjusted seconds non-negative
	localparam logic [33:0] SECS_BIAS       = 34'd86400;
	localparam logic [33:0] SECS_BIAS_WRAP  = 34'd172800;

	// floor(x / d) = (x * M) >> K over the value range that reaches each unit
	localparam logic [26:0] RECIP_675  = 27'd101806633; // on secs >> 7, K = 36
	localparam logic [16:0] RECIP_3600 = 17'd74566;     // K = 28
	localparam logic [12:0] RECIP_60   = 13'd4370;      // K = 18
	localparam logic [17:0] RECIP_365  = 18'd183861;    // K = 26
	localparam logic [10:0] RECIP_100  = 11'd1311;      // K = 17
	localparam logic [11:0] RECIP_31   = 12'd2115;      // K = 16
	localparam logic [17:0] RECIP_7    = 18'd149797;    // K = 20

	typedef struct packed {
		logic        [32:0] secs_biased;
		logic signed [17:0] day_base;
	} epcal_item_t;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] month_day;
		logic [3:0] month;
		logic [8:0] years_since_1900;
		logic [8:0] year_day;
		logic [2:0] week_day;
	} epcal_result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} epcal_queue_status_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} epcal_back_status_t;

	// first day of month idx (0..12) within the year
	function automatic logic [8:0] month_first_day(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		case (idx)
			4'd0: base = 9'd0;
			4'd1: base = 9'd31;
			4'd2: base = 9'd59;
			4'd3: base = 9'd90;
			4'd4: base = 9'd120;
			4'd5: base = 9'd151;
			4'd6: base = 9'd181;
			4'd7: base = 9'd212;
			4'd8: base = 9'd243;
			4'd9: base = 9'd273;
			4'd10: base = 9'd304;
			4'd11: base = 9'd334;
			4'd12: base = 9'd365;
			default: base = 9'd0;
		endcase
		if (leap && idx >= 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ----- sv/epcal_front.sv -----
// ----------------------------------------------------------------------------
// epcal_front: configuration registers and input classification
// Holds the base day count and zone offset, folds the half-day wrap and the
// offset into a biased seconds value and a day base, and pushes the item.
// ----------------------------------------------------------------------------
module epcal_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [epcal_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [epcal_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        elapsed_seconds,
	input  epcal_pkg::epcal_queue_status_t     qstat,
	output logic                               push,
	output epcal_pkg::epcal_item_t             push_item
);

	logic        [15:0] base_days_q;
	logic signed [16:0] zone_offset_q;
	logic               wrap;
	logic        [33:0] secs_sum;
	logic        [17:0] day_base;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_days_q   <= epcal_pkg::BASE_DAYS_RESET;
			zone_offset_q <= '0;
		end else if (cfg_valid) begin
			case (epcal_pkg::cfg_reg_t'(cfg_index))
				epcal_pkg::REG_EPOCH_BASE_DAYS: base_days_q <= cfg_data[15:0];
				epcal_pkg::REG_ZONE_OFFSET_SECONDS: zone_offset_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// early seconds with a positive offset borrow a day from the base
	assign wrap = (elapsed_seconds < epcal_pkg::HALF_DAY_SECS) && !zone_offset_q[16]
		&& (zone_offset_q != '0);

	assign secs_sum = {2'b00, elapsed_seconds}
		+ (wrap ? epcal_pkg::SECS_BIAS_WRAP : epcal_pkg::SECS_BIAS)
		- {{17{zone_offset_q[16]}}, zone_offset_q};

	// minus one more day to undo the bias
	assign day_base = {2'b00, base_days_q} - {17'b0, wrap} - 18'd1;

	assign in_stall              = qstat.full;
	assign push                  = in_valid && !qstat.full;
	assign push_item.secs_biased = secs_sum[32:0];
	assign push_item.day_base    = $signed(day_base);

endmodule

// ----- sv/epcal_queue.sv -----
// ----------------------------------------------------------------------------
// epcal_queue: two-entry queue between front and back
// Lets the front take a new item while the back is still converting.
// ----------------------------------------------------------------------------
module epcal_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  epcal_pkg::epcal_item_t         push_item,
	input  logic                           pop,
	output epcal_pkg::epcal_item_t         head,
	output epcal_pkg::epcal_queue_status_t qstat
);

	epcal_pkg::epcal_item_t entry_q [2];
	logic [1:0]             count_q;
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

endmodule

// ----- sv/epcal_back.sv -----
// ----------------------------------------------------------------------------
// epcal_back: conversion sequencer and output register
// Walks one item through the day split, time of day, year estimate and
// correction, weekday and month lookup, with at most two multiplies per step.
// ----------------------------------------------------------------------------
module epcal_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  epcal_pkg::epcal_queue_status_t qstat,
	input  epcal_pkg::epcal_item_t        head,
	output epcal_pkg::epcal_back_status_t bstat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output epcal_pkg::epcal_result_t      result
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_DAY   = 14'b00000000000010,
		ST_SPLIT = 14'b00000000000100,
		ST_HOUR  = 14'b00000000001000,
		ST_MREM  = 14'b00000000010000,
		ST_MIN   = 14'b00000000100000,
		ST_SEC   = 14'b00000001000000,
		ST_WDAY  = 14'b00000010000000,
		ST_YPRE  = 14'b00000100000000,
		ST_YSUM  = 14'b00001000000000,
		ST_YCHK  = 14'b00010000000000,
		ST_MEST  = 14'b00100000000000,
		ST_MFIX  = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load_out;

	logic        [32:0] x_q;
	logic signed [17:0] dbase_q;
	logic        [16:0] qd_q;
	logic        [16:0] r_q;
	logic signed [17:0] days_q;
	logic        [4:0]  hour_q;
	logic        [5:0]  minute_q;
	logic        [5:0]  second_q;
	logic        [8:0]  year_q;
	logic        [14:0] wq_q;
	logic        [2:0]  wday_q;
	logic        [5:0]  p100_q;
	logic        [17:0] dby_q;
	logic        [6:0]  rp100_q;
	logic        [8:0]  doy_q;
	logic               leap_q;
	logic        [3:0]  mon_q;
	logic        [4:0]  mday_q;
	epcal_pkg::epcal_result_t result_q;

	logic        [52:0] day_prod;
	logic        [33:0] day_secs;
	logic        [32:0] rem_secs;
	logic        [33:0] hr_prod;
	logic        [16:0] hr_secs;
	logic        [24:0] mn_prod;
	logic        [11:0] mn_secs;
	logic        [11:0] sec_full;
	logic        [34:0] yr_prod;
	logic        [16:0] dp1;
	logic        [34:0] wd_prod;
	logic        [16:0] wd_back;
	logic        [16:0] wd_rem;
	logic        [11:0] prior;
	logic        [22:0] pr_prod;
	logic        [17:0] yr_days;
	logic        [17:0] dby;
	logic        [11:0] rp100;
	logic signed [18:0] doy;
	logic               doy_neg;
	logic               y_cent;
	logic        [5:0]  y_q100;
	logic               leap;
	logic        [20:0] ms_prod;
	logic        [4:0]  m_est;
	logic        [8:0]  next_start;
	logic               m_step;
	logic        [3:0]  m_fix;
	logic        [8:0]  mday_full;

	// days and seconds of day from the biased seconds
	assign day_prod = 53'(x_q[32:7]) * 53'(epcal_pkg::RECIP_675);
	assign day_secs = 34'(qd_q) * 34'd86400;
	assign rem_secs = x_q - day_secs[32:0];

	assign hr_prod  = 34'(r_q) * 34'(epcal_pkg::RECIP_3600);
	assign hr_secs  = 17'(hour_q) * 17'd3600;
	assign mn_prod  = 25'(r_q[11:0]) * 25'(epcal_pkg::RECIP_60);
	assign mn_secs  = 12'(minute_q) * 12'd60;
	assign sec_full = r_q[11:0] - mn_secs;

	assign yr_prod  = 35'(days_q[16:0]) * 35'(epcal_pkg::RECIP_365);
	assign dp1      = days_q[16:0] + 17'd1;
	assign wd_prod  = 35'(dp1) * 35'(epcal_pkg::RECIP_7);
	assign wd_back  = 17'(wq_q) * 17'd7;
	assign wd_rem   = dp1 - wd_back;

	// days before Jan 1 of the estimated year
	assign prior   = 12'd1899 + 12'(year_q);
	assign pr_prod = 23'(prior) * 23'(epcal_pkg::RECIP_100);
	assign yr_days = 18'(year_q) * 18'd365;
	assign dby     = yr_days + 18'(prior[11:2]) + 18'(p100_q[5:2]) - 18'(p100_q) - 18'd460;
	assign rp100   = prior - 12'(p100_q) * 12'd100;

	assign doy     = {days_q[17], days_q} - $signed({1'b0, dby_q});
	assign doy_neg = doy[18];

	// leap rule for the year after prior
	assign y_cent = (rp100_q == 7'd99);
	assign y_q100 = p100_q + {5'b0, y_cent};
	assign leap   = ((year_q[1:0] == 2'b00) && !y_cent) || (y_cent && (y_q100[1:0] == 2'b00));

	assign ms_prod    = 21'(doy_q) * 21'(epcal_pkg::RECIP_31);
	assign m_est      = ms_prod[20:16];
	assign next_start = epcal_pkg::month_first_day(leap_q, mon_q + 4'd1);
	assign m_step     = (mon_q < 4'd11) && (doy_q >= next_start);
	assign m_fix      = m_step ? mon_q + 4'd1 : mon_q;
	assign mday_full  = doy_q - epcal_pkg::month_first_day(leap_q, m_fix) + 9'd1;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					state_d = ST_DAY;
				end
			end
			ST_DAY:   state_d = ST_SPLIT;
			ST_SPLIT: state_d = ST_HOUR;
			ST_HOUR:  state_d = ST_MREM;
			ST_MREM:  state_d = ST_MIN;
			ST_MIN:   state_d = ST_SEC;
			ST_SEC:   state_d = ST_WDAY;
			ST_WDAY:  state_d = days_q[17] ? ST_DONE : ST_YPRE;
			ST_YPRE:  state_d = ST_YSUM;
			ST_YSUM:  state_d = ST_YCHK;
			ST_YCHK: begin
				// step the year back until Jan 1 is not after the day
				if (doy_neg && year_q != 9'd0) begin
					state_d = ST_YPRE;
				end else begin
					state_d = ST_MEST;
				end
			end
			ST_MEST:  state_d = ST_MFIX;
			ST_MFIX:  state_d = ST_DONE;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= head.secs_biased;
				dbase_q <= head.day_base;
			end
			ST_DAY: qd_q <= day_prod[52:36];
			ST_SPLIT: begin
				r_q    <= rem_secs[16:0];
				days_q <= dbase_q + $signed({1'b0, qd_q});
			end
			ST_HOUR: hour_q <= hr_prod[32:28];
			ST_MREM: r_q <= r_q - hr_secs;
			ST_MIN:  minute_q <= mn_prod[23:18];
			ST_SEC: begin
				second_q <= sec_full[5:0];
				year_q   <= yr_prod[34:26];
			end
			ST_WDAY: wq_q <= wd_prod[34:20];
			ST_YPRE: begin
				wday_q <= wd_rem[2:0];
				p100_q <= pr_prod[22:17];
			end
			ST_YSUM: begin
				dby_q   <= dby;
				rp100_q <= rp100[6:0];
			end
			ST_YCHK: begin
				if (doy_neg && year_q != 9'd0) begin
					year_q <= year_q - 9'd1;
				end else begin
					doy_q  <= doy_neg ? 9'd0 : doy[8:0];
					leap_q <= leap;
				end
			end
			ST_MEST: mon_q <= (m_est > 5'd11) ? 4'd11 : m_est[3:0];
			ST_MFIX: begin
				mon_q  <= m_fix;
				mday_q <= mday_full[4:0];
			end
			ST_DONE: begin
				if (load_out) begin
					result_q.second <= second_q;
					result_q.minute <= minute_q;
					result_q.hour   <= hour_q;
					// before 1900 the date reads as Jan 1 1900
					if (days_q[17]) begin
						result_q.month_day        <= 5'd1;
						result_q.month            <= 4'd0;
						result_q.years_since_1900 <= 9'd0;
						result_q.year_day         <= 9'd0;
						result_q.week_day         <= 3'd1;
					end else begin
						result_q.month_day        <= mday_q;
						result_q.month            <= mon_q;
						result_q.years_since_1900 <= year_q;
						result_q.year_day         <= doy_q;
						result_q.week_day         <= wday_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign bstat.idle = (state_q == ST_IDLE);
	assign bstat.pop  = (state_q == ST_IDLE) && !qstat.empty;
	assign out_valid  = out_valid_q;
	assign result     = result_q;

endmodule

// ----- sv/epoch_seconds_to_calendar_core.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: seconds since epoch to broken-down time
// Front classification, two-entry queue and conversion sequencer.
// ----------------------------------------------------------------------------
// Each item picked up from the queue runs through the conversion steps to one
// result; the year steps repeat when the year estimate is one year high and
// has to step back (it is never more than one year high), and a date before
// 1900 skips the year and month steps. The conversion sequencer takes one
// multiply-based step per cycle, holds one item at a time and waits with the finished result while the output stalls.
// Two more items can wait in the queue and one finished result in the output
// register. Write the configuration registers only while no item is in flight.
module epoch_seconds_to_calendar_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [epcal_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [epcal_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       elapsed_seconds,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [5:0]                        second,
	output logic [5:0]                        minute,
	output logic [4:0]                        hour,
	output logic [4:0]                        month_day,
	output logic [3:0]                        month,
	output logic [8:0]                        years_since_1900,
	output logic [8:0]                        year_day,
	output logic [2:0]                        week_day
);

	epcal_pkg::epcal_queue_status_t qstat;
	epcal_pkg::epcal_back_status_t  bstat;
	epcal_pkg::epcal_item_t         push_item;
	epcal_pkg::epcal_item_t         head;
	epcal_pkg::epcal_result_t       result;
	logic                           push;

	epcal_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.elapsed_seconds (elapsed_seconds),
		.qstat           (qstat),
		.push            (push),
		.push_item       (push_item)
	);

	epcal_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (bstat.pop),
		.head      (head),
		.qstat     (qstat)
	);

	epcal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.bstat     (bstat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign second           = result.second;
	assign minute           = result.minute;
	assign hour             = result.hour;
	assign month_day        = result.month_day;
	assign month            = result.month;
	assign years_since_1900 = result.years_since_1900;
	assign year_day         = result.year_day;
	assign week_day         = result.week_day;

	// time of day stays in range after the reciprocal divisions
	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
		else $error("time of day out of range");

	// date fields stay in range after the year correction and month step
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month < 4'd12) && (month_day != 5'd0) && (year_day < 9'd366)
			&& (week_day < 3'd7))
		else $error("date field out of range");

	// a waiting item is picked up by an idle sequencer
	a_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		(bstat.idle && !qstat.empty) |=> !bstat.idle)
		else $error("queued item not picked up");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for epoch_seconds_to_calendar_core
// Streams second counts through the core under several base-day and zone
// offset settings and checks every broken-down time field it produces.
// ----------------------------------------------------------------------------
module tb;

	// indexes past the register list, written to check that they are ignored
	localparam logic [epcal_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [epcal_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	localparam longint SECS_PER_DAY = 86400;
	localparam longint HALF_DAY     = 43200;

	class calendar_scoreboard;
		epcal_pkg::epcal_result_t expected_dates[$];
		int unsigned      mismatches;
		logic [15:0]      base_days;
		logic signed [16:0] zone_offset;
		int               month_first[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
			273, 304, 334, 365};

		function new();
			base_days   = epcal_pkg::BASE_DAYS_RESET;
			zone_offset = '0;
			mismatches  = 0;
		endfunction

		function void set_register(logic [epcal_pkg::CFG_INDEX_W-1:0] idx,
			logic [epcal_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				epcal_pkg::REG_EPOCH_BASE_DAYS:     base_days = data[15:0];
				epcal_pkg::REG_ZONE_OFFSET_SECONDS: zone_offset = data;
				default: ;
			endcase
		endfunction

		function bit leap_year(longint y);
			return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
		endfunction

		function longint start_of_month(bit leap, longint m);
			return month_first[m] + ((leap && m >= 2) ? 1 : 0);
		endfunction

		function epcal_pkg::epcal_result_t convert(logic [31:0] elapsed);
			longint secs, days, q, r, year, doy, m, prior;
			bit leap;
			epcal_pkg::epcal_result_t res;
			secs = elapsed;
			days = base_days;
			if (secs < HALF_DAY && zone_offset > 0) begin
				secs += SECS_PER_DAY;
				days -= 1;
			end
			secs -= zone_offset;
			q = secs / SECS_PER_DAY;
			r = secs % SECS_PER_DAY;
			// floor division so the time of day never goes negative
			if (r < 0) begin
				r += SECS_PER_DAY;
				q -= 1;
			end
			days += q;
			res.hour   = 5'(r / 3600);
			res.minute = 6'((r % 3600) / 60);
			res.second = 6'(r % 60);
			// dates before 1900 clamp to jan 1 1900, a monday
			res.month_day        = 5'd1;
			res.month            = 4'd0;
			res.years_since_1900 = 9'd0;
			res.year_day         = 9'd0;
			res.week_day         = 3'd1;
			if (days >= 0) begin
				year  = days / 365;
				prior = 1899 + year;
				doy   = days - (year * 365 + prior / 4 - prior / 100 + prior / 400 - 460);
				while (doy < 0 && year > 0) begin
					year -= 1;
					doy  += 365 + (leap_year(year + 1900) ? 1 : 0);
				end
				if (doy < 0)
					doy = 0;
				leap = leap_year(year + 1900);
				m = doy / 31;
				if (m > 11)
					m = 11;
				if (m < 11 && doy >= start_of_month(leap, m + 1))
					m += 1;
				res.month            = 4'(m);
				res.month_day        = 5'(doy - start_of_month(leap, m) + 1);
				res.years_since_1900 = 9'(year);
				res.year_day         = 9'(doy);
				res.week_day         = 3'((days + 1) % 7);
			end
			return res;
		endfunction

		function void note_input(logic [31:0] elapsed);
			expected_dates.push_back(convert(elapsed));
		endfunction

		function void check_result(epcal_pkg::epcal_result_t got);
			epcal_pkg::epcal_result_t want;
			if (expected_dates.size() == 0) begin
				$error("result with no transfer pending");
				mismatches++;
				return;
			end
			want = expected_dates.pop_front();
			if (got.second !== want.second) begin
				$error("second: expected %0d, got %0d", want.second, got.second);
				mismatches++;
			end
			if (got.minute !== want.minute) begin
				$error("minute: expected %0d, got %0d", want.minute, got.minute);
				mismatches++;
			end
			if (got.hour !== want.hour) begin
				$error("hour: expected %0d, got %0d", want.hour, got.hour);
				mismatches++;
			end
			if (got.month_day !== want.month_day) begin
				$error("month_day: expected %0d, got %0d", want.month_day, got.month_day);
				mismatches++;
			end
			if (got.month !== want.month) begin
				$error("month: expected %0d, got %0d", want.month, got.month);
				mismatches++;
			end
			if (got.years_since_1900 !== want.years_since_1900) begin
				$error("years_since_1900: expected %0d, got %0d", want.years_since_1900,
					got.years_since_1900);
				mismatches++;
			end
			if (got.year_day !== want.year_day) begin
				$error("year_day: expected %0d, got %0d", want.year_day, got.year_day);
				mismatches++;
			end
			if (got.week_day !== want.week_day) begin
				$error("week_day: expected %0d, got %0d", want.week_day, got.week_day);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [epcal_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [epcal_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [31:0]                       elapsed_seconds = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [5:0]                        second;
	logic [5:0]                        minute;
	logic [4:0]                        hour;
	logic [4:0]                        month_day;
	logic [3:0]                        month;
	logic [8:0]                        years_since_1900;
	logic [8:0]                        year_day;
	logic [2:0]                        week_day;
	epcal_pkg::epcal_result_t          dut_result;
	bit                                long_hold = 1'b0;

	calendar_scoreboard dates = new();

	epoch_seconds_to_calendar_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.elapsed_seconds  (elapsed_seconds),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.second           (second),
		.minute           (minute),
		.hour             (hour),
		.month_day        (month_day),
		.month            (month),
		.years_since_1900 (years_since_1900),
		.year_day         (year_day),
		.week_day         (week_day)
	);

	assign dut_result = {second, minute, hour, month_day, month, years_since_1900, year_day,
		week_day};

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			dates.note_input(elapsed_seconds);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			dates.check_result(dut_result);
	end

	// receiver: random stalls, calm stretches and one long hold-off
	initial begin
		int unsigned mode, span;
		@(posedge clk iff arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				mode = $urandom_range(0, 19);
				if (mode < 12) begin
					out_stall <= 1'($urandom_range(0, 1));
					span = $urandom_range(1, 3);
				end else if (mode < 16) begin
					out_stall <= 1'b0;
					span = $urandom_range(30, 120);
				end else begin
					out_stall <= 1'b1;
					span = $urandom_range(10, 40);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	function int unsigned pick_gap();
		int unsigned mode;
		if (long_hold)
			return 0;
		mode = $urandom_range(0, 19);
		if (mode < 10)
			return 0;
		if (mode < 16)
			return $urandom_range(1, 3);
		if (mode < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_seconds(logic [31:0] value);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		elapsed_seconds <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_register(logic [epcal_pkg::CFG_INDEX_W-1:0] idx,
		logic [epcal_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		dates.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// all results back, then let the sequencer go quiet before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (dates.pending() != 0);
		repeat (40) @(posedge clk);
	endtask

	function logic [31:0] pick_seconds();
		int unsigned mode;
		logic [31:0] day;
		mode = $urandom_range(0, 9);
		day  = $urandom_range(1, 49000);
		case (mode)
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(0, 100000);
			6:          return 32'hFFFF_FFFF - $urandom_range(0, 200000);
			7:          return day * 86400 - 1 + $urandom_range(0, 2);
			default:    return day * 86400 + $urandom_range(0, 86399);
		endcase
	endfunction

	initial begin
		int phase, n, pick, offset;
		logic [15:0] base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: day and year boundaries, leap day, extremes of the count
		send_seconds(32'd0);
		send_seconds(32'd43199);
		send_seconds(32'd43200);
		send_seconds(32'd86399);
		send_seconds(32'd86400);
		send_seconds(32'd68169600);
		send_seconds(32'd946684799);
		send_seconds(32'd951782400);
		send_seconds(32'hFFFF_FFFF);
		send_seconds(32'h7FFF_FFFF);
		drain();

		// zero base with a positive offset lands before 1900
		write_register(epcal_pkg::REG_EPOCH_BASE_DAYS, 17'd0);
		write_register(epcal_pkg::REG_ZONE_OFFSET_SECONDS, 17'(50400));
		send_seconds(32'd0);
		send_seconds(32'd43200);
		send_seconds(32'hFFFF_FFFF);
		drain();

		// largest base with the most negative offset in range
		write_register(epcal_pkg::REG_EPOCH_BASE_DAYS, 17'd65535);
		write_register(epcal_pkg::REG_ZONE_OFFSET_SECONDS, 17'(-50400));
		send_seconds(32'd0);
		send_seconds(32'hFFFF_FFFF);
		drain();

		// full 17-bit offsets past the stated range, spare indexes change nothing
		write_register(epcal_pkg::REG_EPOCH_BASE_DAYS, 17'(epcal_pkg::BASE_DAYS_RESET));
		write_register(epcal_pkg::REG_ZONE_OFFSET_SECONDS, 17'h10000);
		write_register(REG_SPARE_A, 17'h1FFFF);
		send_seconds(32'hFFFF_FFFF);
		send_seconds(32'd12345);
		drain();
		write_register(epcal_pkg::REG_ZONE_OFFSET_SECONDS, 17'h0FFFF);
		write_register(REG_SPARE_B, 17'h0);
		send_seconds(32'd1000);
		send_seconds(32'd50000);
		drain();

		for (phase = 0; phase < 8; phase++) begin
			pick = $urandom_range(0, 4);
			case (pick)
				0:       base = 16'd0;
				1:       base = 16'd65535;
				2:       base = epcal_pkg::BASE_DAYS_RESET;
				default: base = 16'($urandom);
			endcase
			pick = $urandom_range(0, 4);
			case (pick)
				0:       offset = -50400;
				1:       offset = 50400;
				2:       offset = 0;
				3:       offset = int'($urandom_range(0, 100800)) - 50400;
				default: offset = int'($urandom_range(0, 17'h1FFFF));
			endcase
			write_register(epcal_pkg::REG_EPOCH_BASE_DAYS, {1'b0, base});
			write_register(epcal_pkg::REG_ZONE_OFFSET_SECONDS, 17'(offset));
			if (phase == 0)
				long_hold = 1'b1;
			for (n = 0; n < 125; n++)
				send_seconds(pick_seconds());
			drain();
		end

		if (dates.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
